/* hdl/box_average_thumbnail_downscaler_core_defines.svh */
// Assertion macros for the box-average thumbnail downscaler.
// No dependencies; included by the RTL files that carry checks.
`ifndef BOX_AVERAGE_THUMBNAIL_DOWNSCALER_CORE_DEFINES_SVH
`define BOX_AVERAGE_THUMBNAIL_DOWNSCALER_CORE_DEFINES_SVH
`ifndef SYNTH
`define BATD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("batd assertion failed");
`define BATD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("batd assertion failed");
`else
`define BATD_ASSERT(lbl, prop)
`define BATD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hdl/batd_pkg.sv */
// Shared types, constants and helpers for the thumbnail downscaler.
// No dependencies.
`default_nettype none
package batd_pkg;
  localparam int THUMB_SIZE     = 128;
  localparam int THUMB_W        = $clog2(THUMB_SIZE);
  localparam int MAX_SOURCE_DIM = 4096;
  localparam int DIM_W          = 13;
  localparam int POS_W          = 12;
  localparam int CHAN_W         = 8;
  localparam int SUM_W          = 18;
  localparam int SPAN_W         = 6;
  localparam int CNT_W          = 11;
  localparam int MEM_DEPTH      = 2 * THUMB_SIZE;
  localparam int ADDR_W         = THUMB_W + 1;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RMW, ST_CNT, ST_DIV_INIT, ST_DIV, ST_OUT, ST_ADV, ST_MUL
  } batd_state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_W'(THUMB_SIZE)) return DIM_W'(THUMB_SIZE);
    if (v > DIM_W'(MAX_SOURCE_DIM)) return DIM_W'(MAX_SOURCE_DIM);
    return v;
  endfunction
endpackage
`default_nettype wire

/* hdl/box_average_thumbnail_downscaler_core.sv */
// Sequence: each cell update is a read (ST_RD) and a read-modify-write (ST_RMW),
// up to 4 per pixel, then a position advance; a pixel that closes a cell adds a
// count multiply, a restoring division per channel and an output step that waits while a held result is not taken.
// Throughput: one pixel at a time, set by the single accumulator memory port
// and the shared multiplier / restoring divider.
// Reset (sync, rst_n low): 128x128 source, position (0,0), all sums empty.
`default_nettype none
`include "box_average_thumbnail_downscaler_core_defines.svh"
module box_average_thumbnail_downscaler_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [batd_pkg::CHAN_W-1:0]    in_red_in,
  input  wire  [batd_pkg::CHAN_W-1:0]    in_green_in,
  input  wire  [batd_pkg::CHAN_W-1:0]    in_blue_in,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [batd_pkg::THUMB_W-1:0]   out_thumb_col,
  output logic [batd_pkg::THUMB_W-1:0]   out_thumb_row,
  output logic [batd_pkg::CHAN_W-1:0]    out_red_out,
  output logic [batd_pkg::CHAN_W-1:0]    out_green_out,
  output logic [batd_pkg::CHAN_W-1:0]    out_blue_out,
  output logic [batd_pkg::CHAN_W-1:0]    out_alpha_out,
  output logic                           out_frame_done,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [1:0]                     cfg_index,
  input  wire  [batd_pkg::DIM_W-1:0]     cfg_data
);
  import batd_pkg::*;

  localparam logic [THUMB_W-1:0] LAST_CELL = THUMB_W'(THUMB_SIZE - 1);

  batd_state_t state_r, state_nxt;

  // effective (saturated) source dimensions
  logic [DIM_W-1:0] eff_w_r, eff_h_r;

  // source position and per-axis window trackers:
  // hi = last cell whose window starts at or before pos,
  // prev/cur/next = window starts of cells hi-1, hi, hi+1
  logic [POS_W-1:0]   col_pos_r, row_pos_r;
  logic [THUMB_W-1:0] col_hi_r, row_hi_r;
  logic [DIM_W-1:0]   col_prev_r, col_cur_r, col_next_r;
  logic [DIM_W-1:0]   row_prev_r, row_cur_r, row_next_r;

  logic [CHAN_W-1:0] pix_r [3];
  logic              i_r, j_r, emitted_r, mul_row_r;

  // accumulator memory: {blue, green, red} sums, address {row parity, col}
  logic [3*SUM_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [3*SUM_W-1:0] rd_q_r;
  logic               rd_vld_r;

  logic [SUM_W-1:0]   sum_r [3];
  logic [THUMB_W-1:0] cell_x_r, cell_y_r;
  logic [SPAN_W-1:0]  wc_r, wr_r;
  logic [CNT_W-1:0]   cnt_r;

  // shared restoring divider
  logic [1:0]        ch_r;
  logic [2:0]        step_r;
  logic [SUM_W-1:0]  rem_r, dsh_r;
  logic [CHAN_W-1:0] q_r;
  logic              sat_r;
  logic [CHAN_W-1:0] avg_r [3];

  logic [THUMB_W-1:0] out_col_r, out_row_r;
  logic [CHAN_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic               out_valid_r, out_done_r;

  logic in_fire, cfg_fire, cfg_hit;
  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_fire && (cfg_index == REG_SOURCE_WIDTH ||
                                 cfg_index == REG_SOURCE_HEIGHT);

  // window geometry of the current pixel
  logic [SPAN_W-1:0] span_w, span_h;
  logic [DIM_W-1:0]  col_end_prev, col_end_cur, row_end_prev, row_end_cur;
  logic [DIM_W-1:0]  col_tmp_p, col_tmp_c, row_tmp_p, row_tmp_c;
  logic              col_two, row_two;
  logic [THUMB_W-1:0] x_sel, y_sel;
  logic [DIM_W-1:0]  x_start, y_start, x_end, y_end;
  logic              last_i, last_j, closes;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    span_w = SPAN_W'((eff_w_r + DIM_W'(THUMB_SIZE - 1)) >> THUMB_W);
    span_h = SPAN_W'((eff_h_r + DIM_W'(THUMB_SIZE - 1)) >> THUMB_W);
    col_tmp_p = col_prev_r + DIM_W'(span_w) - 1'b1;
    col_tmp_c = col_cur_r + DIM_W'(span_w) - 1'b1;
    row_tmp_p = row_prev_r + DIM_W'(span_h) - 1'b1;
    row_tmp_c = row_cur_r + DIM_W'(span_h) - 1'b1;
    col_end_prev = (col_tmp_p > eff_w_r - 1'b1) ? eff_w_r - 1'b1 : col_tmp_p;
    col_end_cur  = (col_tmp_c > eff_w_r - 1'b1) ? eff_w_r - 1'b1 : col_tmp_c;
    row_end_prev = (row_tmp_p > eff_h_r - 1'b1) ? eff_h_r - 1'b1 : row_tmp_p;
    row_end_cur  = (row_tmp_c > eff_h_r - 1'b1) ? eff_h_r - 1'b1 : row_tmp_c;
    col_two = (col_hi_r != '0) && (DIM_W'(col_pos_r) <= col_end_prev);
    row_two = (row_hi_r != '0) && (DIM_W'(row_pos_r) <= row_end_prev);
    if (!i_r && col_two) begin
      x_sel = col_hi_r - 1'b1; x_start = col_prev_r; x_end = col_end_prev;
    end else begin
      x_sel = col_hi_r; x_start = col_cur_r; x_end = col_end_cur;
    end
    if (!j_r && row_two) begin
      y_sel = row_hi_r - 1'b1; y_start = row_prev_r; y_end = row_end_prev;
    end else begin
      y_sel = row_hi_r; y_start = row_cur_r; y_end = row_end_cur;
    end
    last_i = i_r || !col_two;
    last_j = j_r || !row_two;
    closes = (x_end == DIM_W'(col_pos_r)) && (y_end == DIM_W'(row_pos_r));
    addr   = {y_sel[0], x_sel};
  end

  // accumulate
  logic [3*SUM_W-1:0] old_sums, new_sums;
  logic               emit_now;
  always_comb begin
    old_sums = rd_vld_r ? rd_q_r : '0;
    for (int k = 0; k < 3; k++) begin
      new_sums[k*SUM_W +: SUM_W] = old_sums[k*SUM_W +: SUM_W] + SUM_W'(pix_r[k]);
    end
    emit_now = closes && !emitted_r;
  end

  // shared multiplier
  logic [DIM_W-1:0]   mul_a;
  logic [7:0]         mul_b;
  logic [DIM_W+7:0]   prod;
  always_comb begin
    if (state_r == ST_CNT) begin
      mul_a = DIM_W'(wr_r);
      mul_b = 8'(wc_r);
    end else begin
      mul_a = mul_row_r ? eff_h_r : eff_w_r;
      mul_b = (mul_row_r ? {1'b0, row_hi_r} : {1'b0, col_hi_r}) + 8'd1;
    end
    prod = (DIM_W+8)'(mul_a) * (DIM_W+8)'(mul_b);
  end

  // divider step
  logic              div_ge;
  logic [CHAN_W-1:0] q_nxt;
  assign div_ge = rem_r >= dsh_r;
  assign q_nxt  = {q_r[CHAN_W-2:0], div_ge};

  // position advance
  logic [DIM_W-1:0] c1, r1;
  assign c1 = DIM_W'(col_pos_r) + 1'b1;
  assign r1 = DIM_W'(row_pos_r) + 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_RMW;
      ST_RMW: begin
        if (!last_i || !last_j)              state_nxt = ST_RD;
        else if (emitted_r || emit_now)      state_nxt = ST_CNT;
        else                                 state_nxt = ST_ADV;
      end
      ST_CNT:      state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == 3'd7) state_nxt = (ch_r == 2'd2) ? ST_OUT : ST_DIV_INIT;
      end
      ST_OUT: if (!out_valid_r || out_ready) state_nxt = ST_ADV;
      ST_ADV: begin
        if (c1 == eff_w_r) begin
          if (r1 != eff_h_r && row_hi_r != LAST_CELL && row_next_r == r1)
            state_nxt = ST_MUL;
          else
            state_nxt = ST_IDLE;
        end else if (col_hi_r != LAST_CELL && col_next_r == c1) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory: one port, registered read
  logic                 mem_we;
  logic [3*SUM_W-1:0]   mem_wd;
  assign mem_we = (state_r == ST_RMW);
  assign mem_wd = emit_now ? '0 : new_sums;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wd;
    if (state_r == ST_RD) begin
      rd_q_r   <= mem[addr];
      rd_vld_r <= vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) vld_r <= '0;
    else if (mem_we)       vld_r[addr] <= 1'b1;
  end

  // position and window trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= DIM_W'(THUMB_SIZE);
      eff_h_r <= DIM_W'(THUMB_SIZE);
      col_pos_r <= '0; row_pos_r <= '0;
      col_hi_r <= '0; row_hi_r <= '0;
      col_prev_r <= '0; col_cur_r <= '0; col_next_r <= DIM_W'(1);
      row_prev_r <= '0; row_cur_r <= '0; row_next_r <= DIM_W'(1);
      mul_row_r <= 1'b0;
    end else if (cfg_hit) begin
      // any write to a source dimension register restarts the frame
      col_pos_r <= '0; row_pos_r <= '0;
      col_hi_r <= '0; row_hi_r <= '0;
      col_prev_r <= '0; col_cur_r <= '0;
      row_prev_r <= '0; row_cur_r <= '0;
      if (cfg_index == REG_SOURCE_WIDTH) begin
        eff_w_r    <= eff_dim(cfg_data);
        col_next_r <= eff_dim(cfg_data) >> THUMB_W;
        row_next_r <= eff_h_r >> THUMB_W;
      end else begin
        eff_h_r    <= eff_dim(cfg_data);
        row_next_r <= eff_dim(cfg_data) >> THUMB_W;
        col_next_r <= eff_w_r >> THUMB_W;
      end
    end else if (state_r == ST_ADV) begin
      if (c1 == eff_w_r) begin
        col_pos_r <= '0; col_hi_r <= '0;
        col_prev_r <= '0; col_cur_r <= '0; col_next_r <= eff_w_r >> THUMB_W;
        if (r1 == eff_h_r) begin
          // frame wrap
          row_pos_r <= '0; row_hi_r <= '0;
          row_prev_r <= '0; row_cur_r <= '0; row_next_r <= eff_h_r >> THUMB_W;
        end else begin
          row_pos_r <= POS_W'(r1);
          if (row_hi_r != LAST_CELL && row_next_r == r1) begin
            row_hi_r <= row_hi_r + 1'b1;
            row_prev_r <= row_cur_r;
            row_cur_r <= row_next_r;
            mul_row_r <= 1'b1;
          end
        end
      end else begin
        col_pos_r <= POS_W'(c1);
        if (col_hi_r != LAST_CELL && col_next_r == c1) begin
          col_hi_r <= col_hi_r + 1'b1;
          col_prev_r <= col_cur_r;
          col_cur_r <= col_next_r;
          mul_row_r <= 1'b0;
        end
      end
    end else if (state_r == ST_MUL) begin
      // start of the cell after hi: (hi+1)*dim/128
      if (mul_row_r) row_next_r <= prod[DIM_W+THUMB_W-1:THUMB_W];
      else           col_next_r <= prod[DIM_W+THUMB_W-1:THUMB_W];
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= 1'b0; j_r <= 1'b0; emitted_r <= 1'b0;
      ch_r <= '0; step_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            pix_r[0] <= in_red_in;
            pix_r[1] <= in_green_in;
            pix_r[2] <= in_blue_in;
            i_r <= 1'b0; j_r <= 1'b0; emitted_r <= 1'b0;
          end
        end
        ST_RMW: begin
          if (emit_now) begin
            emitted_r <= 1'b1;
            for (int k = 0; k < 3; k++) sum_r[k] <= new_sums[k*SUM_W +: SUM_W];
            cell_x_r <= x_sel;
            cell_y_r <= y_sel;
            wc_r <= SPAN_W'(DIM_W'(col_pos_r) - x_start + 1'b1);
            wr_r <= SPAN_W'(DIM_W'(row_pos_r) - y_start + 1'b1);
          end
          if (!last_i) begin
            i_r <= 1'b1;
          end else if (!last_j) begin
            i_r <= 1'b0; j_r <= 1'b1;
          end
        end
        ST_CNT: begin
          cnt_r <= prod[CNT_W-1:0];
          ch_r  <= '0;
        end
        ST_DIV_INIT: begin
          rem_r  <= sum_r[ch_r];
          dsh_r  <= {cnt_r, 7'b0};
          sat_r  <= {1'b0, sum_r[ch_r]} >= {cnt_r, 8'b0};
          q_r    <= '0;
          step_r <= '0;
        end
        ST_DIV: begin
          if (div_ge) rem_r <= rem_r - dsh_r;
          dsh_r  <= dsh_r >> 1;
          q_r    <= q_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == 3'd7) begin
            avg_r[ch_r] <= sat_r ? {CHAN_W{1'b1}} : q_nxt;
            ch_r <= ch_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
      out_col_r   <= cell_x_r;
      out_row_r   <= cell_y_r;
      out_red_r   <= avg_r[0];
      out_green_r <= avg_r[1];
      out_blue_r  <= avg_r[2];
      out_done_r  <= (cell_x_r == LAST_CELL) && (cell_y_r == LAST_CELL);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_thumb_col  = out_col_r;
  assign out_thumb_row  = out_row_r;
  assign out_red_out    = out_red_r;
  assign out_green_out  = out_green_r;
  assign out_blue_out   = out_blue_r;
  assign out_alpha_out  = {CHAN_W{1'b1}};
  assign out_frame_done = out_done_r;

  `BATD_ASSERT(a_busy_after_accept, in_fire |=> !in_ready)
  `BATD_ASSERT(a_done_corner,
    out_valid && out_frame_done |-> out_thumb_col == LAST_CELL && out_thumb_row == LAST_CELL)
  `BATD_ASSERT(a_div_nonzero, state_r == ST_DIV |-> cnt_r != '0)
  `BATD_ASSERT(a_pos_in_image,
    DIM_W'(col_pos_r) < eff_w_r && DIM_W'(row_pos_r) < eff_h_r)
  `BATD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE && !out_valid_r)
endmodule
`default_nettype wire

/* tb/box_average_thumbnail_downscaler_core_test.sv */
// Self-checking bench for the box-average thumbnail downscaler core.
// Depends on batd_pkg and box_average_thumbnail_downscaler_core.
`timescale 1ns / 100ps
module box_average_thumbnail_downscaler_core_test;
  import batd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // index past the register list
  localparam int SETTLE = 64;                // > worst per-pixel work
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [THUMB_W-1:0] col, row;
    logic [CHAN_W-1:0]  red, green, blue, alpha;
    logic               done;
  } thumb_cell_t;

  // directed pixels; where chk is set the cell is typed in directly
  typedef struct {
    logic [CHAN_W-1:0]  red, green, blue;
    bit                 chk;
    logic [THUMB_W-1:0] col, row;
  } pixel_row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [CHAN_W-1:0] in_red = 0, in_green = 0, in_blue = 0;
  logic [1:0] cfg_index = 0;
  logic [DIM_W-1:0] cfg_data = 0;
  wire in_ready, out_valid, cfg_ready, out_frame_done;
  wire [THUMB_W-1:0] out_thumb_col, out_thumb_row;
  wire [CHAN_W-1:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;

  box_average_thumbnail_downscaler_core dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_red_in(in_red), .in_green_in(in_green), .in_blue_in(in_blue),
    .out_valid, .out_ready, .out_thumb_col, .out_thumb_row,
    .out_red_out, .out_green_out, .out_blue_out, .out_alpha_out, .out_frame_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // shadow of the block's state
  int unsigned band_sum [2][THUMB_SIZE][3];
  int unsigned src_col, src_row;
  logic [DIM_W-1:0] width_reg, height_reg;
  thumb_cell_t pending_cells[$];
  int errors = 0, cycles = 0;
  int send_idle = 0, recv_idle = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < THUMB_SIZE) return THUMB_SIZE;
    if (v > MAX_SOURCE_DIM) return MAX_SOURCE_DIM;
    return v;
  endfunction

  function automatic int unsigned box_first(int unsigned i, int unsigned d);
    return (i * d) / THUMB_SIZE;
  endfunction

  function automatic int unsigned box_last(int unsigned i, int unsigned d);
    int unsigned e;
    e = box_first(i, d) + (d + THUMB_SIZE - 1) / THUMB_SIZE - 1;
    return (e > d - 1) ? d - 1 : e;
  endfunction

  task automatic clear_frame();
    band_sum = '{default: 0};
    src_col = 0;
    src_row = 0;
  endtask

  // accumulate one pixel; queue the cell it closes, if any
  task automatic accumulate_pixel(input logic [CHAN_W-1:0] r, g, b);
    int unsigned w, h, c, q, cnt, avg, hx, hy;
    int unsigned chan [3];
    bit closed;
    thumb_cell_t cell_exp;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    c = (src_col >= w) ? 0 : src_col;
    q = (src_row >= h) ? 0 : src_row;
    chan = '{r, g, b};
    closed = 0;
    hx = ((c + 1) * THUMB_SIZE - 1) / w;
    hy = ((q + 1) * THUMB_SIZE - 1) / h;
    if (hx > THUMB_SIZE - 1) hx = THUMB_SIZE - 1;
    if (hy > THUMB_SIZE - 1) hy = THUMB_SIZE - 1;
    for (int y = (hy > 0 ? hy - 1 : hy); y <= hy; y++) begin
      if (box_first(y, h) > q || q > box_last(y, h)) continue;
      for (int x = (hx > 0 ? hx - 1 : hx); x <= hx; x++) begin
        if (box_first(x, w) > c || c > box_last(x, w)) continue;
        for (int k = 0; k < 3; k++) band_sum[y % 2][x][k] += chan[k];
        if (!closed && box_last(x, w) == c && box_last(y, h) == q) begin
          cnt = (c - box_first(x, w) + 1) * (q - box_first(y, h) + 1);
          cell_exp.col = THUMB_W'(x);
          cell_exp.row = THUMB_W'(y);
          for (int k = 0; k < 3; k++) begin
            avg = band_sum[y % 2][x][k] / cnt;
            chan[k] = (avg > 255) ? 255 : avg;
            band_sum[y % 2][x][k] = 0;
          end
          cell_exp.red = CHAN_W'(chan[0]);
          cell_exp.green = CHAN_W'(chan[1]);
          cell_exp.blue = CHAN_W'(chan[2]);
          cell_exp.alpha = 8'hff;
          cell_exp.done = (x == THUMB_SIZE - 1 && y == THUMB_SIZE - 1);
          pending_cells.push_back(cell_exp);
          closed = 1;
          chan = '{r, g, b};
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      q++;
      if (q >= h) q = 0;
    end
    src_col = c;
    src_row = q;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // one pixel request; called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    accumulate_pixel(r, g, b);
    @(negedge clk);
  endtask

  // hold the sender off until every expected cell has been taken
  task automatic drain();
    in_valid <= 0;
    while (pending_cells.size() != 0) @(negedge clk);
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SOURCE_WIDTH) begin
      width_reg = val;
      clear_frame();
    end else if (idx == REG_SOURCE_HEIGHT) begin
      height_reg = val;
      clear_frame();
    end
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // receiver backpressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // compare each accepted cell with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $display("unexpected cell (%0d,%0d) at cycle %0d", out_thumb_col, out_thumb_row,
                 cycles);
        errors++;
      end else begin
        thumb_cell_t e;
        e = pending_cells.pop_front();
        if (out_thumb_col !== e.col) report("thumb_col", out_thumb_col, e.col);
        if (out_thumb_row !== e.row) report("thumb_row", out_thumb_row, e.row);
        if (out_red_out !== e.red) report("red_out", out_red_out, e.red);
        if (out_green_out !== e.green) report("green_out", out_green_out, e.green);
        if (out_blue_out !== e.blue) report("blue_out", out_blue_out, e.blue);
        if (out_alpha_out !== e.alpha) report("alpha_out", out_alpha_out, e.alpha);
        if (out_frame_done !== e.done) report("frame_done", out_frame_done, e.done);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // after reset a 128x128 source maps every pixel onto its own cell
  pixel_row_t directed [] = '{
    '{8'h00, 8'h00, 8'h00, 1, 7'd0, 7'd0},
    '{8'hff, 8'hff, 8'hff, 1, 7'd1, 7'd0},
    '{8'haa, 8'h55, 8'haa, 1, 7'd2, 7'd0},
    '{8'h55, 8'haa, 8'h55, 1, 7'd3, 7'd0},
    '{8'hff, 8'h00, 8'h80, 1, 7'd4, 7'd0},
    '{8'h01, 8'hfe, 8'h7f, 1, 7'd5, 7'd0}
  };

  initial begin
    width_reg = THUMB_SIZE;
    height_reg = THUMB_SIZE;
    clear_frame();
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // phase 1: bursty sender, mostly stalled receiver
    send_idle = 20;
    recv_idle = 81;
    foreach (directed[i]) begin
      int prior_count;
      prior_count = pending_cells.size();
      send_pixel(directed[i].red, directed[i].green, directed[i].blue);
      if (directed[i].chk && pending_cells.size() > prior_count) begin
        thumb_cell_t t;
        t = '{directed[i].col, directed[i].row, directed[i].red, directed[i].green,
              directed[i].blue, 8'hff, 1'b0};
        pending_cells[$] = t;
      end
    end
    write_reg(REG_SPARE, $urandom_range(8191));  // ignored, frame carries on
    send_random(4);
    write_reg(REG_SOURCE_WIDTH, 13'd4096);        // widest windows
    send_random(300);

    // phase 2: the other way round
    send_idle = 81;
    recv_idle = 20;
    write_reg(REG_SOURCE_WIDTH, 13'd200);         // overlapping windows
    write_reg(REG_SOURCE_HEIGHT, 13'd130);
    send_random(200);
    drain();                                      // sender holds off until drained
    @(negedge clk);
    send_random(200);
    write_reg(REG_SOURCE_WIDTH, 13'd0);           // saturates up to 128
    write_reg(REG_SOURCE_HEIGHT, 13'h1fff);       // saturates down to 4096
    send_random(150);

    // phase 3: no idling, back at 128x128
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_SOURCE_WIDTH, 13'd128);
    write_reg(REG_SOURCE_HEIGHT, 13'd128);
    send_random(290);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
